// ===== hw/rtl/scd_pkg.sv =====
// Shared types and constants for the serial command deframer.
// No dependencies; every other file of the block imports this package.
package scd_pkg;

	localparam int BYTE_W   = 8;
	localparam int CODE_W   = 16;
	localparam int LEN_W    = 31;
	localparam int LEN_RX_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int BEAT_W   = 3;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h00;
	localparam logic [BEAT_W-1:0] ECHO_BEATS = 3'd4;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_CODE = 2'd1,
		PH_LEN  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CMD     = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ECHO    = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_COMMAND = 3'd0,
		CFG_MAX_COMMAND   = 3'd1,
		CFG_DATA_CODE_A   = 3'd2,
		CFG_DATA_CODE_B   = 3'd3,
		CFG_DATA_CODE_C   = 3'd4
	} cfg_idx_t;

	localparam logic ERR_BAD_CODE = 1'b0;
	localparam logic ERR_BAD_SIZE = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] first_command;
		logic [CODE_W-1:0] max_command;
		logic [CODE_W-1:0] data_code_a;
		logic [CODE_W-1:0] data_code_b;
		logic [CODE_W-1:0] data_code_c;
	} cfg_t;

	// One burst of results: a head result, optionally followed by the echo bytes.
	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
		logic              err;
		logic              echo;
	} desc_t;

endpackage

// ===== hw/rtl/serial_command_deframer.sv =====
// Top level of the serial command deframer: config registers, parser, emitter.
// Depends on scd_pkg, scd_cfg_regs, scd_decoder and scd_emitter.
//
//   channel  handshake               payload
//   input    in_valid / in_ready     rx_byte
//   output   out_valid / out_ready   out_kind, command_code, payload_length,
//                                    data_byte, error_code, last_of_run
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A received word passes the input register and then the combinational parser, so one word
// per cycle is taken while the result register is free or the word yields no result; its
// first result is offered from the result register. A word that completes a valid frame
// yields five results, one per cycle from the result register while out_ready is high. A
// word that needs the result register meanwhile waits in the input register until the
// burst is through. Reset clears all frame state to hunting; the config port is always
// ready. A stall on the output backs up through the input register to in_ready.
module serial_command_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [scd_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     out_kind,
	output logic [scd_pkg::CODE_W-1:0]     command_code,
	output logic [scd_pkg::LEN_W-1:0]      payload_length,
	output logic [scd_pkg::BYTE_W-1:0]     data_byte,
	output logic                           error_code,
	output logic                           last_of_run,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CODE_W-1:0]     cfg_data
);
	import scd_pkg::*;

	cfg_t  cfg;
	desc_t emit_desc;
	logic  emit_load, emit_free;

	scd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scd_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg       (cfg),
		.emit_free (emit_free),
		.emit_load (emit_load),
		.emit_desc (emit_desc)
	);

	scd_emitter u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (emit_load),
		.desc           (emit_desc),
		.free           (emit_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_kind       (out_kind),
		.command_code   (command_code),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.error_code     (error_code),
		.last_of_run    (last_of_run)
	);

endmodule

// ===== hw/rtl/scd_cfg_regs.sv =====
// Configuration register file of the serial command deframer.
// Depends on scd_pkg for the register index codes and the cfg_t struct.
module scd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [scd_pkg::CODE_W-1:0]     cfg_data,
	output scd_pkg::cfg_t                  cfg
);
	import scd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIRST_COMMAND: cfg_q.first_command <= cfg_data;
				CFG_MAX_COMMAND:   cfg_q.max_command   <= cfg_data;
				CFG_DATA_CODE_A:   cfg_q.data_code_a   <= cfg_data;
				CFG_DATA_CODE_B:   cfg_q.data_code_b   <= cfg_data;
				CFG_DATA_CODE_C:   cfg_q.data_code_c   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/scd_decoder.sv =====
// Input register and frame parser of the serial command deframer.
// Depends on scd_pkg; hands at most one result burst descriptor per byte to the emitter.
module scd_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [scd_pkg::BYTE_W-1:0]  rx_byte,
	input  scd_pkg::cfg_t               cfg,
	input  logic                        emit_free,
	output logic                        emit_load,
	output scd_pkg::desc_t              emit_desc
);
	import scd_pkg::*;

	logic                s1_valid_q;
	logic [BYTE_W-1:0]   byte_s1;

	phase_t              phase_q, phase_d;
	logic                zero_run_q, zero_run_d;
	logic [1:0]          idx_q, idx_d;
	logic [CODE_W-1:0]   cmd_q, cmd_d;
	logic [LEN_RX_W-1:0] len_q, len_d;
	logic [LEN_W-1:0]    rem_q, rem_d;

	logic [CODE_W-1:0]   code_full;
	logic [LEN_RX_W-1:0] len_full;
	logic                code_bad, code_data, len_bad, rem_last;
	logic                has_res, fire;
	desc_t               desc;

	assign code_full = {cmd_q[CODE_W-1:BYTE_W], byte_s1};
	assign len_full  = {len_q[LEN_RX_W-BYTE_W-1:0], byte_s1};
	assign code_bad  = (code_full < cfg.first_command) || (code_full > cfg.max_command);
	assign code_data = (code_full == cfg.data_code_a) || (code_full == cfg.data_code_b) ||
		(code_full == cfg.data_code_c);
	assign len_bad   = (len_full == '0) || len_full[LEN_RX_W-1];
	// The count never starts at zero, so one or zero left means this is the last byte.
	assign rem_last  = (rem_q[LEN_W-1:1] == '0);

	assign fire      = s1_valid_q && (!has_res || emit_free);
	assign in_ready  = !s1_valid_q || fire;
	assign emit_load = fire && has_res;
	assign emit_desc = desc;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SYNC_BYTE && zero_run_q) phase_d = PH_CODE;
			end
			PH_CODE: begin
				if (idx_q != 2'd0) begin
					if (code_bad)       phase_d = PH_HUNT;
					else if (code_data) phase_d = PH_LEN;
					else                phase_d = PH_HUNT;
				end
			end
			PH_LEN: begin
				if (idx_q == 2'd3) phase_d = len_bad ? PH_HUNT : PH_DATA;
			end
			PH_DATA: begin
				if (rem_last) phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		zero_run_d = zero_run_q;
		idx_d      = idx_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		rem_d      = rem_q;
		has_res    = 1'b0;
		desc.kind  = KIND_CMD;
		desc.code  = cmd_q;
		desc.len   = '0;
		desc.data  = '0;
		desc.err   = ERR_BAD_CODE;
		desc.echo  = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SYNC_BYTE) begin
					zero_run_d = !zero_run_q;
					if (zero_run_q) idx_d = 2'd0;
				end else begin
					zero_run_d = 1'b0;
				end
			end
			PH_CODE: begin
				if (idx_q == 2'd0) begin
					cmd_d = {byte_s1, {BYTE_W{1'b0}}};
					idx_d = 2'd1;
				end else begin
					cmd_d     = code_full;
					desc.code = code_full;
					if (code_bad) begin
						has_res   = 1'b1;
						desc.kind = KIND_ERROR;
					end else if (code_data) begin
						idx_d = 2'd0;
						len_d = '0;
					end else begin
						has_res   = 1'b1;
						desc.echo = 1'b1;
					end
				end
			end
			PH_LEN: begin
				len_d = len_full;
				idx_d = idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					has_res = 1'b1;
					if (len_bad) begin
						desc.kind = KIND_ERROR;
						desc.err  = ERR_BAD_SIZE;
					end else begin
						rem_d    = len_full[LEN_W-1:0];
						desc.len = len_full[LEN_W-1:0];
					end
				end
			end
			PH_DATA: begin
				has_res   = 1'b1;
				desc.kind = KIND_PAYLOAD;
				desc.len  = len_q[LEN_W-1:0];
				desc.data = byte_s1;
				desc.echo = rem_last;
				if (rem_q != '0) rem_d = rem_q - LEN_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			zero_run_q <= 1'b0;
			idx_q      <= 2'd0;
			cmd_q      <= '0;
			len_q      <= '0;
			rem_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			zero_run_q <= zero_run_d;
			idx_q      <= idx_d;
			cmd_q      <= cmd_d;
			len_q      <= len_d;
			rem_q      <= rem_d;
		end
	end

`ifndef SYNTHESIS
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> rem_q != '0)
		else $error("payload phase with an empty byte count");
	a_zero_run_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		zero_run_q |-> phase_q == PH_HUNT)
		else $error("sync zero run held outside hunting");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |=> $stable(phase_q))
		else $error("phase changed without a word in the input register");
`endif

endmodule

// ===== hw/rtl/scd_emitter.sv =====
// Result register and echo sequencer of the serial command deframer.
// Depends on scd_pkg; plays out a head result and up to four echo words.
module scd_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  scd_pkg::desc_t              desc,
	output logic                        free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  out_kind,
	output logic [scd_pkg::CODE_W-1:0]  command_code,
	output logic [scd_pkg::LEN_W-1:0]   payload_length,
	output logic [scd_pkg::BYTE_W-1:0]  data_byte,
	output logic                        error_code,
	output logic                        last_of_run
);
	import scd_pkg::*;

	logic              valid_q;
	logic [BEAT_W-1:0] beat_q;
	desc_t             desc_q;
	logic              out_fire, last;

	assign out_fire = valid_q && out_ready;
	assign last     = (beat_q == '0 && !desc_q.echo) || (beat_q == ECHO_BEATS);
	assign free     = !valid_q || (out_fire && last);

	assign out_valid      = valid_q;
	assign command_code   = desc_q.code;
	assign payload_length = desc_q.len;
	assign last_of_run    = last;

	always_comb begin
		out_kind   = KIND_ECHO;
		data_byte  = '0;
		error_code = 1'b0;
		// Echo words are 00 00 code-high code-low.
		case (beat_q)
			3'd0: begin
				out_kind   = desc_q.kind;
				data_byte  = desc_q.data;
				error_code = desc_q.err;
			end
			3'd3:    data_byte = desc_q.code[CODE_W-1:BYTE_W];
			3'd4:    data_byte = desc_q.code[BYTE_W-1:0];
			default: data_byte = SYNC_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (out_fire) begin
			if (last) begin
				valid_q <= 1'b0;
				beat_q  <= '0;
			end else begin
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) desc_q <= desc;
	end

`ifndef SYNTHESIS
	a_echo_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && beat_q != '0 |-> desc_q.echo)
		else $error("echo word sent for a burst without echo");
	a_echo_head: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && desc_q.echo |-> desc_q.kind == KIND_CMD || desc_q.kind == KIND_PAYLOAD)
		else $error("echo attached to an error result");
	a_burst_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && last |=> beat_q == '0)
		else $error("burst did not restart at its head word");
`endif

endmodule

// ===== verif/serial_command_deframer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for serial_command_deframer: directed frames, then random traffic.
// Depends on scd_pkg and the RTL of the block; predicts every result word on its own.
module serial_command_deframer_test;
	import scd_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam longint LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int CHOKE_CYCLES = 300;
	localparam int RESET_CONFIG_ROWS = 8;
	localparam int DIRECTED_ROWS = 33;

	typedef struct packed {
		kind_t             kind;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
		logic              err;
		logic              last;
	} frame_result_t;

	// A row with known set ends a sequence whose single error word is written out here.
	typedef struct packed {
		logic [BYTE_W-1:0] rx;
		logic              known;
		logic [CODE_W-1:0] code;
		logic              err;
	} directed_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] out_kind;
	logic [CODE_W-1:0] command_code;
	logic [LEN_W-1:0] payload_length;
	logic [BYTE_W-1:0] data_byte;
	logic error_code;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CODE_W-1:0] cfg_data = '0;

	serial_command_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.command_code(command_code),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.error_code(error_code),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Deframer state as the testbench sees it.
	cfg_t settings = '0;
	phase_t scan_phase = PH_HUNT;
	logic [1:0] zero_count = '0;
	logic [1:0] field_byte_count = '0;
	logic [CODE_W-1:0] frame_code = '0;
	logic [LEN_RX_W-1:0] frame_length = '0;
	logic [LEN_W-1:0] bytes_left = '0;

	frame_result_t step_results[$];
	frame_result_t expected_results[$];
	int mismatch_count = 0;
	int random_items = 0;
	bit sender_steady = 1'b0;
	bit receiver_steady = 1'b0;
	bit choke_request = 1'b0;

	directed_row_t directed [DIRECTED_ROWS] = '{
		// Reset settings: only code 0000 is valid and it carries data; a zero length follows.
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b1, 16'h0000, ERR_BAD_SIZE},
		// A data code above the valid range is an invalid command.
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h90, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b1, 16'h9000, ERR_BAD_CODE},
		// A length with its top bit set.
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b1, 16'h00FF, ERR_BAD_SIZE},
		// Frame without data.
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h12, 1'b0, 16'h0000, 1'b0},
		'{8'h34, 1'b0, 16'h0000, 1'b0},
		// Data frame with a single payload byte.
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h01, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h00, 1'b0, 16'h0000, 1'b0},
		'{8'h01, 1'b0, 16'h0000, 1'b0},
		'{8'hFF, 1'b0, 16'h0000, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("serial_command_deframer_test: done, errors");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [CODE_W-1:0] code_between(input int lo, input int hi);
		return CODE_W'($urandom_range(hi, lo));
	endfunction

	function automatic bit carries_payload(input logic [CODE_W-1:0] code);
		return code == settings.data_code_a || code == settings.data_code_b ||
			code == settings.data_code_c;
	endfunction

	task automatic add_result(input kind_t kind, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] data, input logic err);
		step_results.push_back(frame_result_t'{kind, frame_code, len, data, err, 1'b0});
	endtask

	task automatic add_echo(input logic [LEN_W-1:0] len);
		add_result(KIND_ECHO, len, SYNC_BYTE, 1'b0);
		add_result(KIND_ECHO, len, SYNC_BYTE, 1'b0);
		add_result(KIND_ECHO, len, frame_code[15:8], 1'b0);
		add_result(KIND_ECHO, len, frame_code[7:0], 1'b0);
	endtask

	// Advances the deframer state by one received byte and leaves its words in step_results.
	task automatic deframe_byte(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		step_results.delete();
		case (scan_phase)
			PH_CODE: begin
				if (field_byte_count == 2'd0) begin
					frame_code = {b, 8'h00};
					field_byte_count = 2'd1;
				end else begin
					frame_code[7:0] = b;
					if (frame_code < settings.first_command ||
							frame_code > settings.max_command) begin
						add_result(KIND_ERROR, '0, '0, ERR_BAD_CODE);
						scan_phase = PH_HUNT;
					end else if (carries_payload(frame_code)) begin
						scan_phase = PH_LEN;
						field_byte_count = 2'd0;
						frame_length = '0;
					end else begin
						add_result(KIND_CMD, '0, '0, 1'b0);
						add_echo('0);
						scan_phase = PH_HUNT;
					end
				end
			end
			PH_LEN: begin
				frame_length = {frame_length[23:0], b};
				field_byte_count = field_byte_count + 2'd1;
				if (field_byte_count == 2'd0) begin
					if (frame_length == '0 || frame_length[LEN_RX_W-1]) begin
						add_result(KIND_ERROR, '0, '0, ERR_BAD_SIZE);
						scan_phase = PH_HUNT;
					end else begin
						bytes_left = frame_length[LEN_W-1:0];
						add_result(KIND_CMD, frame_length[LEN_W-1:0], '0, 1'b0);
						scan_phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				len = frame_length[LEN_W-1:0];
				add_result(KIND_PAYLOAD, len, b, 1'b0);
				if (bytes_left != '0)
					bytes_left = bytes_left - LEN_W'(1);
				if (bytes_left == '0) begin
					add_echo(len);
					scan_phase = PH_HUNT;
				end
			end
			default: begin
				scan_phase = PH_HUNT;
				if (b == SYNC_BYTE) begin
					zero_count = zero_count + 2'd1;
					if (zero_count >= 2'd2) begin
						zero_count = 2'd0;
						field_byte_count = 2'd0;
						scan_phase = PH_CODE;
					end
				end else begin
					zero_count = 2'd0;
				end
			end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic known,
			input frame_result_t known_result);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		deframe_byte(b);
		if (known)
			expected_results.push_back(known_result);
		else
			foreach (step_results[k]) expected_results.push_back(step_results[k]);
	endtask

	task automatic send_word(input logic [BYTE_W-1:0] b);
		send_byte(b, 1'b0, '0);
		random_items++;
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CODE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_FIRST_COMMAND: settings.first_command = value;
			CFG_MAX_COMMAND:   settings.max_command = value;
			CFG_DATA_CODE_A:   settings.data_code_a = value;
			CFG_DATA_CODE_B:   settings.data_code_b = value;
			CFG_DATA_CODE_C:   settings.data_code_c = value;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] last,
			input logic [CODE_W-1:0] code_a, input logic [CODE_W-1:0] code_b,
			input logic [CODE_W-1:0] code_c);
		write_register(CFG_FIRST_COMMAND, first);
		write_register(CFG_MAX_COMMAND, last);
		write_register(CFG_DATA_CODE_A, code_a);
		write_register(CFG_DATA_CODE_B, code_b);
		write_register(CFG_DATA_CODE_C, code_c);
		cfg_valid <= 1'b0;
	endtask

	// A byte that yields no word may still be inside the block when the queue runs empty.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CODE_W-1:0] pick_plain_code();
		logic [CODE_W-1:0] code;
		int r;
		code = CODE_W'($urandom_range(16'hFFFF));
		if (settings.first_command > settings.max_command)
			return code;
		for (int t = 0; t < 8; t++) begin
			r = $urandom_range(9);
			if (r == 0)
				code = settings.first_command;
			else if (r == 1)
				code = settings.max_command;
			else
				code = code_between(settings.first_command, settings.max_command);
			if (!carries_payload(code))
				return code;
		end
		return code;
	endfunction

	function automatic logic [CODE_W-1:0] pick_bad_code();
		if (settings.first_command > settings.max_command)
			return CODE_W'($urandom_range(16'hFFFF));
		if (settings.first_command > 0 &&
				(settings.max_command == 16'hFFFF || $urandom_range(1) == 0))
			return code_between(0, settings.first_command - 1);
		if (settings.max_command < 16'hFFFF)
			return code_between(settings.max_command + 1, 16'hFFFF);
		return CODE_W'($urandom_range(16'hFFFF));
	endfunction

	task automatic send_random_frame();
		logic [CODE_W-1:0] code;
		logic [LEN_RX_W-1:0] frame_len;
		int choice;
		int r;
		choice = $urandom_range(99);
		if (choice < 8) begin
			// Line noise that ends on a nonzero byte, so the next sync lines up.
			repeat ($urandom_range(5, 1)) send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
			send_byte(BYTE_W'($urandom_range(255, 1)), 1'b0, '0);
			return;
		end
		if (choice < 12) begin
			send_word(SYNC_BYTE);
			send_word(BYTE_W'($urandom_range(255, 1)));
			return;
		end
		send_word(SYNC_BYTE);
		send_word(SYNC_BYTE);
		if (choice < 22)
			code = pick_bad_code();
		else if (choice < 45)
			code = pick_plain_code();
		else begin
			r = $urandom_range(2);
			code = (r == 0) ? settings.data_code_a :
				(r == 1) ? settings.data_code_b : settings.data_code_c;
		end
		send_word(code[15:8]);
		send_word(code[7:0]);
		if (scan_phase != PH_LEN)
			return;
		r = $urandom_range(99);
		if (r < 5)
			frame_len = '0;
		else if (r < 10)
			frame_len = $urandom() | 32'h8000_0000;
		else if (r < 12)
			frame_len = $urandom_range(255, 128);
		else if (r < 27)
			frame_len = $urandom_range(40, 7);
		else
			frame_len = $urandom_range(6, 1);
		send_word(frame_len[31:24]);
		send_word(frame_len[23:16]);
		send_word(frame_len[15:8]);
		send_word(frame_len[7:0]);
		while (scan_phase == PH_DATA) send_word(BYTE_W'($urandom_range(255)));
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		frame_result_t want;
		if (expected_results.size() == 0) begin
			$error("result word with nothing pending: kind %0d code 0x%0h",
				out_kind, command_code);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			check_field("out_kind", 32'(want.kind), 32'(out_kind));
			check_field("command_code", 32'(want.code), 32'(command_code));
			check_field("payload_length", 32'(want.len), 32'(payload_length));
			check_field("data_byte", 32'(want.data), 32'(data_byte));
			check_field("error_code", 32'(want.err), 32'(error_code));
			check_field("last_of_run", 32'(want.last), 32'(last_of_run));
		end
	endtask

	// Result side: checks every accepted word and throttles out_ready.
	initial begin
		int hold_left;
		int choke_left;
		hold_left = 0;
		choke_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				check_result();
			if (choke_request) begin
				choke_request = 1'b0;
				choke_left = CHOKE_CYCLES;
			end
			if (choke_left > 0) begin
				choke_left--;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (receiver_steady || $urandom_range(99) < 65) begin
				out_ready <= 1'b1;
				hold_left = receiver_steady ? 0 : $urandom_range(7);
			end else begin
				out_ready <= 1'b0;
				hold_left = pick_gap();
			end
		end
	end

	initial begin
		int lo;
		int hi;
		int quota;
		int phase_start;
		bit choke_done;
		bit paused;
		choke_done = 1'b0;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == RESET_CONFIG_ROWS) begin
				drain_and_settle();
				load_settings(16'h0010, 16'h7FFF, 16'h0100, 16'h9000, 16'h00FF);
			end
			send_byte(directed[i].rx, directed[i].known, frame_result_t'{KIND_ERROR,
				directed[i].code, '0, '0, directed[i].err, 1'b1});
		end

		for (int p = 0; p < 6; p++) begin
			drain_and_settle();
			case (p)
				0: load_settings(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
					code_between(0, 16'hFFFF));
				1: begin
					lo = $urandom_range(16'h7FFF);
					hi = lo + $urandom_range(16'h7FFF);
					load_settings(CODE_W'(lo), CODE_W'(hi), code_between(lo, hi),
						code_between(lo, hi), code_between(lo, hi));
				end
				2: begin
					lo = $urandom_range(16'hFF00);
					hi = lo + $urandom_range(48, 8);
					load_settings(CODE_W'(lo), CODE_W'(hi), code_between(lo, hi),
						code_between(lo, hi), code_between(lo, hi));
				end
				3: begin
					// One valid code, and it carries data.
					lo = $urandom_range(16'hFFFF);
					load_settings(CODE_W'(lo), CODE_W'(lo), CODE_W'(lo),
						code_between(0, 16'hFFFF), code_between(0, 16'hFFFF));
				end
				4: load_settings(16'hFFFF, 16'h0000, code_between(0, 16'hFFFF),
					code_between(0, 16'hFFFF), code_between(0, 16'hFFFF));
				default: begin
					lo = $urandom_range(255);
					hi = 16'hFFFF - $urandom_range(255);
					load_settings(CODE_W'(lo), CODE_W'(hi), CODE_W'(lo), CODE_W'(hi),
						code_between(lo, hi));
				end
			endcase
			sender_steady = (p == 0);
			receiver_steady = (p == 0);
			quota = (p == 4) ? 20 : 80;
			phase_start = random_items;
			while (random_items - phase_start < quota) begin
				if (p == 2 && !choke_done && random_items - phase_start >= 20) begin
					// The receiver stops for a long stretch while bytes keep coming.
					choke_request = 1'b1;
					choke_done = 1'b1;
					sender_steady = 1'b1;
				end
				if (p == 3 && !paused && random_items - phase_start >= 40) begin
					drain_and_settle();
					paused = 1'b1;
				end
				send_random_frame();
			end
		end

		drain_and_settle();
		if (mismatch_count == 0)
			$display("serial_command_deframer_test: done, clean");
		else
			$display("serial_command_deframer_test: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/scd_pkg.sv
hw/rtl/scd_cfg_regs.sv
hw/rtl/scd_decoder.sv
hw/rtl/scd_emitter.sv
hw/rtl/serial_command_deframer.sv
verif/serial_command_deframer_test.sv
